// ===== sv/scl_pkg.sv =====
// Shared types, codes and helpers of the shell command lexer.
`timescale 1ns / 1ps

package scl_pkg;

  // Default longest line; positions saturate one below it, at most 4095
  localparam int MAX_LINE_DEFAULT = 4096;

  // Field widths and caps
  localparam int POS_W   = 12;
  localparam int LEN_W   = 12;
  localparam logic [LEN_W-1:0] LEN_CAP = {LEN_W{1'b1}};

  // One character can raise at most this many tokens
  localparam int MAX_RESULTS = 3;
  localparam int RES_CNT_W   = 2;

  // Result queue depth and its pointer and count widths
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Character codes
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_GREAT = 8'h3E;
  localparam logic [7:0] CH_LESS  = 8'h3C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_SQ     = 3'd2,
    MODE_DQ     = 3'd3,
    MODE_PGREAT = 3'd4,
    MODE_PLESS  = 3'd5
  } lex_mode_t;

  typedef enum logic [2:0] {
    KIND_WORD  = 3'd0,
    KIND_PIPE  = 3'd1,
    KIND_GREAT = 3'd2,
    KIND_LESS  = 3'd3,
    KIND_GG    = 3'd4,
    KIND_LL    = 3'd5,
    KIND_END   = 3'd6
  } token_kind_t;

  typedef struct packed {
    token_kind_t        token_kind;
    logic [POS_W-1:0]   start_pos;
    logic [LEN_W-1:0]   length;
    logic               unclosed_quote;
    logic               last_of_line;
  } result_t;

  // Results raised by one accepted beat, written to the queue together
  typedef struct packed {
    logic [RES_CNT_W-1:0]           count;
    result_t [MAX_RESULTS-1:0]      item;
  } res_push_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PIPE) || (c == CH_GREAT) || (c == CH_LESS);
  endfunction

  function automatic result_t make_res(input token_kind_t kind,
                                       input logic [POS_W-1:0] start,
                                       input logic [LEN_W-1:0] len,
                                       input logic unc,
                                       input logic last);
    result_t r;
    r.token_kind     = kind;
    r.start_pos      = start;
    r.length         = len;
    r.unclosed_quote = unc;
    r.last_of_line   = last;
    return r;
  endfunction

endpackage

// ===== sv/scl_res_fifo.sv =====
// Result queue: takes up to three tokens per cycle, hands out one per beat.
`timescale 1ns / 1ps

module scl_res_fifo (
  input  logic                clk,
  input  logic                rst,
  input  scl_pkg::res_push_t  push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_ready,
  output scl_pkg::result_t    out_item
);

  localparam int PW = scl_pkg::FIFO_PTR_W;
  localparam int CW = scl_pkg::FIFO_CNT_W;

  scl_pkg::result_t mem [scl_pkg::FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          pop;

  // Room for a full set of results from the next beat
  assign room      = count <= CW'(scl_pkg::FIFO_DEPTH - scl_pkg::MAX_RESULTS);
  assign out_valid = count != '0;
  assign pop       = out_valid && out_ready;
  assign out_item  = mem[rd_ptr];

  assign count_next = count + CW'(push.count) - CW'(pop);

  // Write the new results in order behind the tail
  always_ff @(posedge clk) begin
    for (int i = 0; i < scl_pkg::MAX_RESULTS; i++) begin
      if (scl_pkg::RES_CNT_W'(i) < push.count) begin
        mem[wr_ptr + PW'(i)] <= push.item[i];
      end
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count_next;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(scl_pkg::FIFO_DEPTH))
    else $error("result queue over full");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != '0) |-> room)
    else $error("results pushed without room");

  a_pop_only: assert property (@(posedge clk) disable iff (rst)
    (pop && push.count == '0) |=> count == $past(count) - CW'(1))
    else $error("occupancy lost track of a pop");
`endif

endmodule

// ===== sv/shell_command_lexer.sv =====
// Top level of the shell command lexer: tokenises one character per beat.
`timescale 1ns / 1ps
// Tokens a character raises are written to the result queue and leave it on m_* in order.
// Throughput: one character per cycle; a character raises zero to three tokens,
// and s_tready drops while the four-entry result queue has fewer than three free slots.
// Reset: synchronous rst empties the result queue and returns the lexer to idle
// at position zero; the same state is restored after each end-of-line beat.

module shell_command_lexer #(
  parameter int MAX_LINE = scl_pkg::MAX_LINE_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: [7:0] ch
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  // m_tdata: [11:0] start_pos, [23:12] length
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  // m_tuser: [2:0] token_kind, [3] unclosed_quote
  output logic [3:0]  m_tuser,
  output logic        m_tlast
);

  localparam int PW = scl_pkg::POS_W;
  localparam int LW = scl_pkg::LEN_W;
  localparam int RW = scl_pkg::RES_CNT_W;
  localparam logic [PW-1:0] POS_CAP =
    PW'(((MAX_LINE - 1) < 4095) ? (MAX_LINE - 1) : 4095);

  scl_pkg::lex_mode_t mode;
  scl_pkg::lex_mode_t mode_next;
  logic [PW-1:0]      word_start;
  logic [PW-1:0]      word_start_next;
  logic [PW-1:0]      position;
  logic [PW-1:0]      position_next;
  logic [LW-1:0]      word_len;
  logic [LW-1:0]      word_len_next;

  scl_pkg::res_push_t step;
  scl_pkg::res_push_t push;
  scl_pkg::result_t   out_item;
  logic               room;
  logic               accept;

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  // Work out the next lexer state and the tokens this character raises
  always_comb begin
    logic [7:0]    c;
    logic          run_idle;
    logic [RW-1:0] n;
    c               = s_tdata;
    run_idle        = 1'b0;
    n               = '0;
    step            = '0;
    mode_next       = mode;
    word_start_next = word_start;
    word_len_next   = word_len;

    case (mode)
      scl_pkg::MODE_PGREAT: begin
        mode_next = scl_pkg::MODE_IDLE;
        if (c == scl_pkg::CH_GREAT) begin
          step.item[n] = scl_pkg::make_res(scl_pkg::KIND_GG, word_start, LW'(2), 1'b0, 1'b0);
          n = n + RW'(1);
        end else begin
          step.item[n] = scl_pkg::make_res(scl_pkg::KIND_GREAT, word_start, LW'(1), 1'b0,
                                           1'b0);
          n = n + RW'(1);
          run_idle = 1'b1;
        end
      end
      scl_pkg::MODE_PLESS: begin
        mode_next = scl_pkg::MODE_IDLE;
        if (c == scl_pkg::CH_LESS) begin
          step.item[n] = scl_pkg::make_res(scl_pkg::KIND_LL, word_start, LW'(2), 1'b0, 1'b0);
          n = n + RW'(1);
        end else begin
          step.item[n] = scl_pkg::make_res(scl_pkg::KIND_LESS, word_start, LW'(1), 1'b0,
                                           1'b0);
          n = n + RW'(1);
          run_idle = 1'b1;
        end
      end
      scl_pkg::MODE_WORD: begin
        if (scl_pkg::is_space(c) || scl_pkg::is_op(c)) begin
          step.item[n] = scl_pkg::make_res(scl_pkg::KIND_WORD, word_start, word_len, 1'b0,
                                           1'b0);
          n = n + RW'(1);
          mode_next = scl_pkg::MODE_IDLE;
          run_idle  = 1'b1;
        end else begin
          if (word_len != scl_pkg::LEN_CAP) begin
            word_len_next = word_len + LW'(1);
          end
          if (c == scl_pkg::CH_SQUOTE) begin
            mode_next = scl_pkg::MODE_SQ;
          end else if (c == scl_pkg::CH_DQUOTE) begin
            mode_next = scl_pkg::MODE_DQ;
          end
        end
      end
      scl_pkg::MODE_SQ: begin
        if (word_len != scl_pkg::LEN_CAP) begin
          word_len_next = word_len + LW'(1);
        end
        if (c == scl_pkg::CH_SQUOTE) begin
          mode_next = scl_pkg::MODE_WORD;
        end
      end
      scl_pkg::MODE_DQ: begin
        if (word_len != scl_pkg::LEN_CAP) begin
          word_len_next = word_len + LW'(1);
        end
        if (c == scl_pkg::CH_DQUOTE) begin
          mode_next = scl_pkg::MODE_WORD;
        end
      end
      default: begin
        mode_next = scl_pkg::MODE_IDLE;
        run_idle  = 1'b1;
      end
    endcase

    // Start a new token from idle unless the character is whitespace
    if (run_idle && !scl_pkg::is_space(c)) begin
      word_start_next = position;
      if (c == scl_pkg::CH_PIPE) begin
        step.item[n] = scl_pkg::make_res(scl_pkg::KIND_PIPE, position, LW'(1), 1'b0, 1'b0);
        n = n + RW'(1);
      end else if (c == scl_pkg::CH_GREAT) begin
        mode_next = scl_pkg::MODE_PGREAT;
      end else if (c == scl_pkg::CH_LESS) begin
        mode_next = scl_pkg::MODE_PLESS;
      end else begin
        word_len_next = LW'(1);
        if (c == scl_pkg::CH_SQUOTE) begin
          mode_next = scl_pkg::MODE_SQ;
        end else if (c == scl_pkg::CH_DQUOTE) begin
          mode_next = scl_pkg::MODE_DQ;
        end else begin
          mode_next = scl_pkg::MODE_WORD;
        end
      end
    end

    // Advance the saturating position
    position_next = (position < POS_CAP) ? position + PW'(1) : position;

    // Close the pending token, emit the end marker and fall back to reset state
    if (s_tlast) begin
      case (mode_next)
        scl_pkg::MODE_PGREAT: begin
          step.item[n] = scl_pkg::make_res(scl_pkg::KIND_GREAT, word_start_next, LW'(1),
                                           1'b0, 1'b0);
          n = n + RW'(1);
        end
        scl_pkg::MODE_PLESS: begin
          step.item[n] = scl_pkg::make_res(scl_pkg::KIND_LESS, word_start_next, LW'(1),
                                           1'b0, 1'b0);
          n = n + RW'(1);
        end
        scl_pkg::MODE_WORD: begin
          step.item[n] = scl_pkg::make_res(scl_pkg::KIND_WORD, word_start_next,
                                           word_len_next, 1'b0, 1'b0);
          n = n + RW'(1);
        end
        scl_pkg::MODE_SQ, scl_pkg::MODE_DQ: begin
          step.item[n] = scl_pkg::make_res(scl_pkg::KIND_WORD, word_start_next,
                                           word_len_next, 1'b1, 1'b0);
          n = n + RW'(1);
        end
        default: begin
        end
      endcase
      step.item[n] = scl_pkg::make_res(scl_pkg::KIND_END, position_next, LW'(0), 1'b0, 1'b1);
      n = n + RW'(1);
      mode_next       = scl_pkg::MODE_IDLE;
      word_start_next = '0;
      position_next   = '0;
      word_len_next   = '0;
    end

    step.count = n;
  end

  // Push results only for an accepted beat
  always_comb begin
    push = step;
    if (!accept) begin
      push.count = '0;
    end
  end

  // Hold lexer state between beats
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= scl_pkg::MODE_IDLE;
      word_start <= '0;
      position   <= '0;
      word_len   <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      word_start <= word_start_next;
      position   <= position_next;
      word_len   <= word_len_next;
    end
  end

  scl_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  // Pack the result beat
  assign m_tdata = {out_item.length, out_item.start_pos};
  assign m_tuser = {out_item.unclosed_quote, out_item.token_kind};
  assign m_tlast = out_item.last_of_line;

`ifndef SYNTHESIS
  a_line_reset: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (mode == scl_pkg::MODE_IDLE) && (position == '0)
                            && (word_len == '0))
    else $error("lexer state not cleared after end of line");

  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (out_item.token_kind == scl_pkg::KIND_END)))
    else $error("end marker and last flag disagree");

  a_unclosed_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_item.unclosed_quote) |-> (out_item.token_kind == scl_pkg::KIND_WORD))
    else $error("unclosed quote flagged on a non-word token");

  a_pos_cap: assert property (@(posedge clk) disable iff (rst)
    position <= POS_CAP)
    else $error("position past its cap");
`endif

endmodule

// ===== test/tb_shell_command_lexer.sv =====
// Testbench for the shell command lexer: directed and random lines, checked by a token predictor.
`timescale 1ns / 1ps

module tb_shell_command_lexer;

  localparam int PW          = scl_pkg::POS_W;
  localparam int LW          = scl_pkg::LEN_W;
  localparam int POS_CAP     =
    (scl_pkg::MAX_LINE_DEFAULT - 1 < 4095) ? scl_pkg::MAX_LINE_DEFAULT - 1 : 4095;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_WORD   = 20;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic [3:0]  m_tuser;
  logic        m_tlast;

  // Predictor state and the tokens still owed by the block
  scl_pkg::lex_mode_t lex_state;
  logic [PW-1:0]      tok_start;
  logic [PW-1:0]      line_pos;
  logic [LW-1:0]      word_len;
  scl_pkg::result_t   token_q[$];

  int err_count;
  bit src_idle_en;
  bit snk_idle_en;
  bit hold_off_req;

  shell_command_lexer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit is_blank(input logic [7:0] c);
    return (c == scl_pkg::CH_SPACE) || ((c >= scl_pkg::CH_TAB) && (c <= scl_pkg::CH_CR));
  endfunction

  function automatic bit is_oper(input logic [7:0] c);
    return (c == scl_pkg::CH_PIPE) || (c == scl_pkg::CH_GREAT) || (c == scl_pkg::CH_LESS);
  endfunction

  function automatic void reset_lexer();
    lex_state = scl_pkg::MODE_IDLE;
    tok_start = '0;
    line_pos  = '0;
    word_len  = '0;
  endfunction

  function automatic void push_token(input scl_pkg::token_kind_t kind,
                                     input logic [PW-1:0] start,
                                     input logic [LW-1:0] len, input logic unc,
                                     input logic last);
    scl_pkg::result_t r;
    r.token_kind     = kind;
    r.start_pos      = start;
    r.length         = len;
    r.unclosed_quote = unc;
    r.last_of_line   = last;
    token_q.push_back(r);
  endfunction

  function automatic void grow_word();
    if (word_len != scl_pkg::LEN_CAP) word_len = word_len + 1'b1;
  endfunction

  // Start a token on byte c at offset p while nothing is open
  function automatic void open_token(input logic [7:0] c, input logic [PW-1:0] p);
    if (!is_blank(c)) begin
      tok_start = p;
      if (c == scl_pkg::CH_PIPE) begin
        push_token(scl_pkg::KIND_PIPE, p, LW'(1), 1'b0, 1'b0);
      end else if (c == scl_pkg::CH_GREAT) begin
        lex_state = scl_pkg::MODE_PGREAT;
      end else if (c == scl_pkg::CH_LESS) begin
        lex_state = scl_pkg::MODE_PLESS;
      end else begin
        word_len = LW'(1);
        if (c == scl_pkg::CH_SQUOTE) lex_state = scl_pkg::MODE_SQ;
        else if (c == scl_pkg::CH_DQUOTE) lex_state = scl_pkg::MODE_DQ;
        else lex_state = scl_pkg::MODE_WORD;
      end
    end
  endfunction

  // Work out the tokens raised by one accepted character
  function automatic void tokenise_char(input logic [7:0] c, input logic eol);
    logic [PW-1:0] p;
    bit            great;
    p = line_pos;
    case (lex_state)
      scl_pkg::MODE_PGREAT, scl_pkg::MODE_PLESS: begin
        great     = (lex_state == scl_pkg::MODE_PGREAT);
        lex_state = scl_pkg::MODE_IDLE;
        if (c == (great ? scl_pkg::CH_GREAT : scl_pkg::CH_LESS)) begin
          push_token(great ? scl_pkg::KIND_GG : scl_pkg::KIND_LL, tok_start, LW'(2),
                     1'b0, 1'b0);
        end else begin
          push_token(great ? scl_pkg::KIND_GREAT : scl_pkg::KIND_LESS, tok_start, LW'(1),
                     1'b0, 1'b0);
          open_token(c, p);
        end
      end
      scl_pkg::MODE_WORD: begin
        if (is_blank(c) || is_oper(c)) begin
          push_token(scl_pkg::KIND_WORD, tok_start, word_len, 1'b0, 1'b0);
          lex_state = scl_pkg::MODE_IDLE;
          open_token(c, p);
        end else begin
          grow_word();
          if (c == scl_pkg::CH_SQUOTE) lex_state = scl_pkg::MODE_SQ;
          else if (c == scl_pkg::CH_DQUOTE) lex_state = scl_pkg::MODE_DQ;
        end
      end
      scl_pkg::MODE_SQ: begin
        grow_word();
        if (c == scl_pkg::CH_SQUOTE) lex_state = scl_pkg::MODE_WORD;
      end
      scl_pkg::MODE_DQ: begin
        grow_word();
        if (c == scl_pkg::CH_DQUOTE) lex_state = scl_pkg::MODE_WORD;
      end
      default: begin
        lex_state = scl_pkg::MODE_IDLE;
        open_token(c, p);
      end
    endcase

    if (p < POS_CAP) line_pos = p + 1'b1;

    // Close whatever is pending, then mark the end of the line
    if (eol) begin
      case (lex_state)
        scl_pkg::MODE_PGREAT:
          push_token(scl_pkg::KIND_GREAT, tok_start, LW'(1), 1'b0, 1'b0);
        scl_pkg::MODE_PLESS:
          push_token(scl_pkg::KIND_LESS, tok_start, LW'(1), 1'b0, 1'b0);
        scl_pkg::MODE_WORD:
          push_token(scl_pkg::KIND_WORD, tok_start, word_len, 1'b0, 1'b0);
        scl_pkg::MODE_SQ, scl_pkg::MODE_DQ:
          push_token(scl_pkg::KIND_WORD, tok_start, word_len, 1'b1, 1'b0);
        default: ;
      endcase
      push_token(scl_pkg::KIND_END, line_pos, LW'(0), 1'b0, 1'b1);
      reset_lexer();
    end
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  // Offer one character and hold it until the beat is taken
  task automatic send_char(input logic [7:0] c, input logic eol);
    int gap;
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eol;
    do @(posedge clk); while (!s_tready);
    tokenise_char(c, eol);
  endtask

  task automatic send_text(input string s, input bit eol);
    for (int i = 0; i < s.len(); i++) send_char(s[i], eol && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] word_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (is_blank(c) || is_oper(c) || c == scl_pkg::CH_SQUOTE ||
           c == scl_pkg::CH_DQUOTE);
    return c;
  endfunction

  // Mostly lexically meaningful bytes, with some raw noise
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return word_char();
    if (r < 6) begin
      r = $urandom_range(0, 5);
      return (r == 0) ? scl_pkg::CH_SPACE : scl_pkg::CH_TAB + 8'(r - 1);
    end
    if (r < 8) begin
      r = $urandom_range(0, 4);
      return (r == 0) ? scl_pkg::CH_PIPE : (r < 3) ? scl_pkg::CH_GREAT : scl_pkg::CH_LESS;
    end
    if (r == 8) return $urandom_range(0, 1) ? scl_pkg::CH_SQUOTE : scl_pkg::CH_DQUOTE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_lines(input int n_items);
    int sent;
    int len;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 24);
      for (int j = 0; j < len; j++) send_char(pick_char(), j == len - 1);
      sent += len;
    end
  endtask

  // ---------------------------------------------------------------- tests

  // Every token kind, operator pairing, quoting, NUL and 0xFF, blank-only lines
  task automatic test_directed();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    // leading blank, NUL word, pipe, then a single quote left open at line end
    send_char(scl_pkg::CH_SPACE, 1'b0);
    send_char(8'h00, 1'b0);
    send_text("|'a >\"", 1'b1);
    // triple great, then a less still pending at line end
    send_text(">>><", 1'b1);
    // less pair, mixed operators, 0xFF word with a closed double quote, trailing blank
    send_text("<<>|", 1'b0);
    send_char(8'hFF, 1'b0);
    send_text("\"x y\"z", 1'b0);
    send_char(scl_pkg::CH_TAB, 1'b1);
    // blank-only line over every whitespace code
    for (logic [7:0] c = scl_pkg::CH_TAB; c <= scl_pkg::CH_CR; c++) send_char(c, 1'b0);
    send_char(scl_pkg::CH_SPACE, 1'b1);
    // double quote left open
    send_text("\"'", 1'b1);
    // closed single quote, great pending at line end
    send_text("'b'>", 1'b1);
  endtask

  // Long word broken by a blank, then a pipe and a one-character word at line end
  task automatic test_long_line();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    for (int i = 0; i < LONG_WORD; i++) send_char(word_char(), 1'b0);
    send_char(scl_pkg::CH_SPACE, 1'b0);
    send_char(scl_pkg::CH_PIPE, 1'b0);
    send_char(word_char(), 1'b1);
  endtask

  task automatic test_random();
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    send_random_lines(100);
  endtask

  // Stall the sink for a long stretch while operators and word characters keep arriving
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    snk_idle_en  = 1'b0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 40; i++) begin
      case ($urandom_range(0, 3))
        0: send_char(scl_pkg::CH_PIPE, 1'b0);
        1: send_char(scl_pkg::CH_GREAT, 1'b0);
        2: send_char(scl_pkg::CH_LESS, 1'b0);
        default: send_char(word_char(), 1'b0);
      endcase
    end
    send_char(scl_pkg::CH_PIPE, 1'b1);
  endtask

  task automatic test_full_rate();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    send_random_lines(60);
  endtask

  // ---------------------------------------------------------------- result side

  // Sink: random stalls, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (snk_idle_en && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic void check_field(input string name, input logic [11:0] want,
                                      input logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  // Compare each token beat with the oldest prediction
  always @(posedge clk) begin
    scl_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (token_q.size() == 0) begin
        $error("token_kind: expected none, got %0d", m_tuser[2:0]);
        err_count++;
      end else begin
        want = token_q.pop_front();
        check_field("token_kind", 12'(want.token_kind), 12'(m_tuser[2:0]));
        check_field("start_pos", want.start_pos, m_tdata[11:0]);
        check_field("length", want.length, m_tdata[23:12]);
        check_field("unclosed_quote", 12'(want.unclosed_quote), 12'(m_tuser[3]));
        check_field("last_of_line", 12'(want.last_of_line), 12'(m_tlast));
      end
    end
  end

  // Watchdog: end the run after too long without any beat
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("shell_command_lexer: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    err_count    = 0;
    src_idle_en  = 1'b0;
    snk_idle_en  = 1'b0;
    hold_off_req = 1'b0;
    reset_lexer();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_long_line();
    test_random();
    test_backpressure();
    test_full_rate();

    // Drain, then wait for stray beats
    s_tvalid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (err_count == 0) $display("shell_command_lexer: match");
    else $display("shell_command_lexer: mismatch");
    $finish;
  end

endmodule
